// ===== src/jpeg_marker_segment_scanner_top_defines.svh =====
// ----------------------------------------------------------------------------
// jpeg_marker_segment_scanner_top_defines
// Assertion macros for the marker segment scanner.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_SEGMENT_SCANNER_TOP_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JPMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jpms_pkg.sv =====
// ----------------------------------------------------------------------------
// jpms_pkg
// Types and constants shared by the JPEG marker segment scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jpms_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  marker_code;
        logic [15:0] segment_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        is_color;
    } t_out;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD
    } t_phase;

    localparam logic [2:0] EV_SEGMENT   = 3'd0;
    localparam logic [2:0] EV_SCAN_OK   = 3'd1;
    localparam logic [2:0] EV_EOI       = 3'd2;
    localparam logic [2:0] EV_TRUNC     = 3'd3;
    localparam logic [2:0] EV_BAD_LEN   = 3'd4;
    localparam logic [2:0] EV_SHORT_SOF = 3'd5;
    localparam logic [2:0] EV_COM_FIX   = 3'd6;

    // comment fix-up budget
    localparam logic [1:0] BUDGET_SPENT = 2'd0;
    localparam logic [1:0] BUDGET_IDLE  = 2'd1;
    localparam logic [1:0] BUDGET_ARMED = 2'd2;
    localparam logic [1:0] BUDGET_USED  = 2'd3;

    localparam logic [7:0]  BYTE_FILL   = 8'hFF;
    localparam logic [7:0]  MK_SOS      = 8'hDA;
    localparam logic [7:0]  MK_EOI      = 8'hD9;
    localparam logic [7:0]  MK_COM      = 8'hFE;
    localparam logic [15:0] LEN_MIN     = 16'd2;
    localparam logic [15:0] LEN_SOF_MIN = 16'd8;
    localparam logic [7:0]  NCOMP_COLOR = 8'd3;

    function automatic logic is_frame_marker(input logic [7:0] m);
        is_frame_marker = (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8)
                          && (m != 8'hCC);
    endfunction

endpackage

`default_nettype wire

// ===== src/jpms_core.sv =====
// ----------------------------------------------------------------------------
// jpms_core
// Marker/length/payload tracking; one byte per transaction, result decided
// in the cycle the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jpms_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire jpms_pkg::t_in i_item,
    output logic               o_res_valid,
    output jpms_pkg::t_out     o_res
);
    import jpms_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic        r_prev_com, n_prev_com;
    logic [1:0]  r_budget, n_budget;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_color, n_color;
    logic        r_finished, n_finished;
    logic [15:0] r_stage_w, n_stage_w;
    logic [15:0] r_stage_h, n_stage_h;
    logic [7:0]  r_stage_n, n_stage_n;

    logic [7:0]  w_b;
    logic        w_eof;
    logic        w_live;
    logic        w_fix_active;
    logic [15:0] w_len_now;
    logic [15:0] w_count_inc;
    logic        w_seg_end;
    logic        w_frame;
    logic        w_frame_len_ok;
    logic        w_stop_marker;

    assign w_b          = i_item.data_byte;
    assign w_eof        = i_item.end_of_file;
    assign w_live       = i_take && !r_finished;
    assign w_fix_active = r_prev_com && (r_budget inside {BUDGET_IDLE, BUDGET_ARMED});
    assign w_len_now    = ((r_phase == PH_LEN_LO) && !w_eof) ? {r_len[15:8], w_b} : r_len;
    assign w_count_inc  = r_count + 16'd1;
    assign w_frame      = is_frame_marker(r_marker);
    assign w_frame_len_ok = (w_len_now >= LEN_SOF_MIN);
    assign w_stop_marker  = (r_marker == MK_SOS) || (r_marker == MK_EOI)
                            || (w_frame && !w_frame_len_ok);
    assign w_seg_end = ((r_phase == PH_LEN_LO) && (w_len_now == LEN_MIN))
                     || ((r_phase == PH_PAYLOAD)
                         && (({1'b0, w_count_inc} + 17'd2) >= {1'b0, r_len}));

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_marker   = r_marker;
        n_len      = r_len;
        n_count    = r_count;
        n_prev_com = r_prev_com;
        n_budget   = r_budget;
        n_width    = r_width;
        n_height   = r_height;
        n_color    = r_color;
        n_finished = r_finished;
        n_stage_w  = r_stage_w;
        n_stage_h  = r_stage_h;
        n_stage_n  = r_stage_n;
        if (w_live) begin
            if (w_eof) begin
                n_finished = 1'b1;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (w_fix_active) begin
                            if (w_b != BYTE_FILL) begin
                                n_budget = r_budget - 2'd1;
                            end else begin
                                n_prev_com = 1'b0;
                            end
                        end else if (w_b != BYTE_FILL) begin
                            n_marker = w_b;
                            n_len    = '0;
                            n_count  = '0;
                            n_phase  = PH_LEN_HI;
                            if (r_prev_com && (r_budget == BUDGET_SPENT)) begin
                                n_budget   = BUDGET_USED;
                                n_prev_com = 1'b0;
                            end
                        end
                    end
                    PH_LEN_HI: begin
                        n_len   = {w_b, 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len     = w_len_now;
                        n_stage_w = '0;
                        n_stage_h = '0;
                        n_stage_n = '0;
                        n_count   = '0;
                        if (w_len_now < LEN_MIN) begin
                            n_finished = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        case (r_count)
                            16'd1:   n_stage_h = {w_b, 8'h00};
                            16'd2:   n_stage_h = {r_stage_h[15:8], w_b};
                            16'd3:   n_stage_w = {w_b, 8'h00};
                            16'd4:   n_stage_w = {r_stage_w[15:8], w_b};
                            16'd5:   n_stage_n = w_b;
                            default: ;
                        endcase
                        n_count = w_count_inc;
                    end
                    default: ;
                endcase
                if (w_seg_end) begin
                    if (w_stop_marker) begin
                        n_finished = 1'b1;
                    end else begin
                        if (w_frame) begin
                            n_width  = n_stage_w;
                            n_height = n_stage_h;
                            n_color  = (n_stage_n == NCOMP_COLOR);
                        end
                        n_prev_com = (r_marker == MK_COM);
                        if ((r_marker == MK_COM)
                            && (r_budget inside {BUDGET_IDLE, BUDGET_ARMED})) begin
                            n_budget = BUDGET_ARMED;
                        end
                        n_phase  = PH_SEEK;
                        n_marker = '0;
                        n_len    = '0;
                        n_count  = '0;
                    end
                end
            end
        end
    end

    // result
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.event_res      = EV_SEGMENT;
        o_res.marker_code    = ((r_phase == PH_SEEK) && !w_eof) ? w_b : r_marker;
        o_res.segment_length = w_len_now;
        o_res.image_width    = n_width;
        o_res.image_height   = n_height;
        o_res.is_color       = n_color;
        if (w_live) begin
            if (w_eof) begin
                o_res_valid     = 1'b1;
                o_res.event_res = EV_TRUNC;
                o_res.image_width  = r_width;
                o_res.image_height = r_height;
                o_res.is_color     = r_color;
            end else if ((r_phase == PH_SEEK) && !w_fix_active && (w_b != BYTE_FILL)
                         && r_prev_com && (r_budget == BUDGET_SPENT)) begin
                o_res_valid     = 1'b1;
                o_res.event_res = EV_COM_FIX;
            end else if ((r_phase == PH_LEN_LO) && (w_len_now < LEN_MIN)) begin
                o_res_valid     = 1'b1;
                o_res.event_res = EV_BAD_LEN;
            end else if (w_seg_end) begin
                o_res_valid = 1'b1;
                if (r_marker == MK_SOS) begin
                    o_res.event_res = EV_SCAN_OK;
                end else if (r_marker == MK_EOI) begin
                    o_res.event_res = EV_EOI;
                end else if (w_frame && !w_frame_len_ok) begin
                    o_res.event_res = EV_SHORT_SOF;
                end else begin
                    o_res.event_res = EV_SEGMENT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK;
            r_marker   <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_prev_com <= 1'b0;
            r_budget   <= BUDGET_IDLE;
            r_width    <= '0;
            r_height   <= '0;
            r_color    <= 1'b0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_marker   <= n_marker;
            r_len      <= n_len;
            r_count    <= n_count;
            r_prev_com <= n_prev_com;
            r_budget   <= n_budget;
            r_width    <= n_width;
            r_height   <= n_height;
            r_color    <= n_color;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage_w <= n_stage_w;
        r_stage_h <= n_stage_h;
        r_stage_n <= n_stage_n;
    end

endmodule

`default_nettype wire

// ===== src/jpeg_marker_segment_scanner_top.sv =====
// ----------------------------------------------------------------------------
// jpeg_marker_segment_scanner_top
// JPEG header scanner: reports segments, frame geometry and scan end.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in       sink       i_in_valid / o_in_ready      i_in_data   (t_in)
//  out      source     o_out_valid / i_out_ready    o_out_data  (t_out)
//
//  One byte per cycle while o_in_ready is high; each result is registered.
//  Result goes to an output register backed by a one-entry skid register;
//  o_in_ready falls only while the skid register holds a transaction.
//  Synchronous reset clears all control state.
//  After scan start, end of image or an error, bytes are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_marker_segment_scanner_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire jpms_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output jpms_pkg::t_out      o_out_data
);
    import jpms_pkg::*;

    `include "jpeg_marker_segment_scanner_top_defines.svh"

    logic   w_take;
    logic   w_res_valid;
    t_out   w_res;
    logic   w_out_fire;

    logic   r_out_valid, n_out_valid;
    logic   r_skid_valid, n_skid_valid;
    t_out   r_out, n_out;
    t_out   r_skid, n_skid;

    assign o_in_ready  = !r_skid_valid;
    assign w_take      = i_in_valid && o_in_ready;
    assign w_out_fire  = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    jpms_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_item      (i_in_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (w_res_valid) begin
                n_out = w_res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    `JPMS_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `JPMS_ASSERT_NOW(a_res_needs_take, w_res_valid, w_take, "result without a transaction")
    `JPMS_ASSERT_NEXT(a_stall_fills_skid, r_out_valid && !i_out_ready && w_res_valid, r_skid_valid, "stalled result lost")
    `JPMS_ASSERT_NOW(a_event_range, o_out_valid, o_out_data.event_res <= EV_COM_FIX, "event code out of range")

endmodule

`default_nettype wire

// ===== dv/jpeg_scan_checker.sv =====
// ----------------------------------------------------------------------------
// jpeg_scan_checker
// Watches both channels of the marker segment scanner. Every byte taken is
// run through a bit-true copy of the scanner's behaviour; each result
// transaction is compared field by field against the oldest event due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module jpeg_scan_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  jpms_pkg::t_in    i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  jpms_pkg::t_out   i_out_data,
    output int               o_mismatches,
    output int               o_pending
);

    import jpms_pkg::*;

    t_phase      phase;
    logic [7:0]  cur_marker;
    logic [15:0] seg_len;
    logic [15:0] payload_cnt;
    logic        after_comment;
    logic [1:0]  budget;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic        colour_q;
    logic        done;
    logic [15:0] stage_w;
    logic [15:0] stage_h;
    logic [7:0]  stage_n;

    t_out        due_events[$];
    int          mismatches = 0;

    function automatic void reset_predictor();
        phase         = PH_SEEK;
        cur_marker    = '0;
        seg_len       = '0;
        payload_cnt   = '0;
        after_comment = 1'b0;
        budget        = BUDGET_IDLE;
        width_q       = '0;
        height_q      = '0;
        colour_q      = 1'b0;
        done          = 1'b0;
        stage_w       = '0;
        stage_h       = '0;
        stage_n       = '0;
    endfunction

    function automatic bit sof_marker(input logic [7:0] m);
        return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
    endfunction

    function automatic t_out snapshot(input logic [2:0] code);
        t_out r;
        r.event_res      = code;
        r.marker_code    = cur_marker;
        r.segment_length = seg_len;
        r.image_width    = width_q;
        r.image_height   = height_q;
        r.is_color       = colour_q;
        return r;
    endfunction

    function automatic t_out close_segment();
        t_out r;
        if (cur_marker == MK_SOS) begin
            done = 1'b1;
            return snapshot(EV_SCAN_OK);
        end
        if (cur_marker == MK_EOI) begin
            done = 1'b1;
            return snapshot(EV_EOI);
        end
        if (sof_marker(cur_marker)) begin
            if (seg_len < LEN_SOF_MIN) begin
                done = 1'b1;
                return snapshot(EV_SHORT_SOF);
            end
            width_q  = stage_w;
            height_q = stage_h;
            colour_q = (stage_n == NCOMP_COLOR);
        end
        r = snapshot(EV_SEGMENT);
        after_comment = (cur_marker == MK_COM);
        if (cur_marker == MK_COM && (budget == BUDGET_IDLE || budget == BUDGET_ARMED)) begin
            budget = BUDGET_ARMED;
        end
        phase       = PH_SEEK;
        cur_marker  = '0;
        seg_len     = '0;
        payload_cnt = '0;
        return r;
    endfunction

    // Advances the scanner copy by one byte; returns 1 when an event is due.
    function automatic bit scan_byte(input t_in tr, output t_out r);
        logic [7:0] b;
        b = tr.data_byte;
        r = '0;
        if (done) return 1'b0;
        if (tr.end_of_file) begin
            done = 1'b1;
            r = snapshot(EV_TRUNC);
            return 1'b1;
        end
        case (phase)
            PH_SEEK: begin
                if (after_comment && (budget == BUDGET_IDLE || budget == BUDGET_ARMED)) begin
                    if (b != BYTE_FILL) budget = budget - 2'd1;
                    else after_comment = 1'b0;
                    return 1'b0;
                end
                if (b == BYTE_FILL) return 1'b0;
                cur_marker  = b;
                seg_len     = '0;
                payload_cnt = '0;
                phase       = PH_LEN_HI;
                if (after_comment && budget == BUDGET_SPENT) begin
                    budget        = BUDGET_USED;
                    after_comment = 1'b0;
                    r = snapshot(EV_COM_FIX);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_LEN_HI: begin
                seg_len = {b, 8'h00};
                phase   = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO: begin
                seg_len     = {seg_len[15:8], b};
                stage_w     = '0;
                stage_h     = '0;
                stage_n     = '0;
                payload_cnt = '0;
                if (seg_len < LEN_MIN) begin
                    done = 1'b1;
                    r = snapshot(EV_BAD_LEN);
                    return 1'b1;
                end
                if (seg_len == LEN_MIN) begin
                    r = close_segment();
                    return 1'b1;
                end
                phase = PH_PAYLOAD;
                return 1'b0;
            end
            default: begin
                case (payload_cnt)
                    16'd1: stage_h = {b, 8'h00};
                    16'd2: stage_h = {stage_h[15:8], b};
                    16'd3: stage_w = {b, 8'h00};
                    16'd4: stage_w = {stage_w[15:8], b};
                    16'd5: stage_n = b;
                    default: ;
                endcase
                payload_cnt = payload_cnt + 16'd1;
                if (int'(payload_cnt) + 2 >= int'(seg_len)) begin
                    r = close_segment();
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out next_ev;
        if (!i_rst_n) begin
            reset_predictor();
            due_events.delete();
        end else begin
            // results first: one taken now belongs to an earlier byte
            if (i_out_valid && i_out_ready) begin
                if (due_events.size() == 0) begin
                    $error("result transaction with none due: event %0d, marker 0x%0h",
                           i_out_data.event_res, i_out_data.marker_code);
                    mismatches++;
                end else begin
                    want = due_events.pop_front();
                    check_field("event_res", want.event_res, i_out_data.event_res);
                    check_field("marker_code", want.marker_code, i_out_data.marker_code);
                    check_field("segment_length", want.segment_length,
                                i_out_data.segment_length);
                    check_field("image_width", want.image_width, i_out_data.image_width);
                    check_field("image_height", want.image_height, i_out_data.image_height);
                    check_field("is_color", want.is_color, i_out_data.is_color);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (scan_byte(i_in_data, next_ev)) due_events.push_back(next_ev);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= due_events.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds JPEG header byte streams to the marker segment scanner: a few fixed
// segments covering frame geometry extremes and the comment fix-up, then
// random well-formed segments, then one randomly chosen way of ending the
// scan. Both channels idle at random; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import jpms_pkg::*;

    typedef enum int {
        END_EOF,
        END_BAD_LEN,
        END_SHORT_SOF,
        END_SCAN,
        END_EOI
    } t_ending;

    localparam int RANDOM_BYTES = 600;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    int    mismatches;
    int    pending;
    logic  calm = 1'b0;
    int    sink_hold = 0;
    int    bytes_sent = 0;

    logic [7:0] sof_codes[13] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
                                  8'hC9, 8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF};

    jpeg_marker_segment_scanner_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    jpeg_scan_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // stretches with no idling on either side
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
    end

    always @(posedge clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            sink_hold <= gap_len();
        end
    end

    task automatic send(input logic [7:0] b, input logic eof);
        int idle;
        idle = gap_len();
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_file: eof};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Fill bytes, marker, length, then payload laid out as a frame header.
    task automatic segment(input logic [7:0] mk, input logic [15:0] len, input int fills,
                           input logic [15:0] h, input logic [15:0] w,
                           input logic [7:0] ncomp);
        logic [7:0] b;
        repeat (fills) send(BYTE_FILL, 1'b0);
        send(mk, 1'b0);
        send(len[15:8], 1'b0);
        send(len[7:0], 1'b0);
        for (int i = 0; i + 2 < int'(len); i++) begin
            case (i)
                1: b = h[15:8];
                2: b = h[7:0];
                3: b = w[15:8];
                4: b = w[7:0];
                5: b = ncomp;
                default: b = 8'($urandom);
            endcase
            send(b, 1'b0);
        end
    endtask

    function automatic logic [15:0] rand_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(2, 10));
        if (r < 95) return 16'($urandom_range(11, 40));
        return 16'($urandom_range(100, 300));
    endfunction

    function automatic logic [7:0] rand_ncomp();
        if ($urandom_range(0, 1) == 0) return NCOMP_COLOR;
        return 8'($urandom);
    endfunction

    task automatic random_segment();
        int          kind;
        int          fills;
        logic [7:0]  mk;
        logic [15:0] len;
        kind  = $urandom_range(0, 99);
        fills = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        if (kind < 25) begin
            mk  = sof_codes[$urandom_range(0, 12)];
            len = ($urandom_range(0, 1) == 0) ? LEN_SOF_MIN : 16'($urandom_range(9, 14));
        end else if (kind < 35) begin
            mk  = MK_COM;
            len = rand_len();
        end else begin
            do mk = 8'($urandom_range(0, 254)); while (mk == MK_SOS || mk == MK_EOI);
            len = rand_len();
            if (mk[7:4] == 4'hC && len < LEN_SOF_MIN) len = LEN_SOF_MIN;
        end
        segment(mk, len, fills, rand_dim(), rand_dim(), rand_ncomp());
    endtask

    task automatic end_scan();
        t_ending how;
        how = t_ending'($urandom_range(0, 4));
        case (how)
            END_EOF: begin
                send(BYTE_FILL, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send(8'hE2, 1'b0);
                    send(8'h00, 1'b0);
                end
                send(8'($urandom), 1'b1);
            end
            END_BAD_LEN:
                segment(8'($urandom_range(0, 254)), 16'($urandom_range(0, 1)), 1,
                        '0, '0, '0);
            END_SHORT_SOF:
                segment(sof_codes[$urandom_range(0, 12)], 16'($urandom_range(2, 7)), 1,
                        rand_dim(), rand_dim(), NCOMP_COLOR);
            END_SCAN:
                segment(MK_SOS, 16'($urandom_range(2, 12)), 1, '0, '0, '0);
            default:
                segment(MK_EOI, LEN_MIN, 1, '0, '0, '0);
        endcase
    endtask

    initial begin : stimulus
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty payload under the smallest marker code
        segment(8'h00, LEN_MIN, 0, '0, '0, '0);
        segment(8'hC0, LEN_SOF_MIN, 2, 16'hFFFF, 16'h0000, NCOMP_COLOR);
        // one stray byte after a comment is swallowed, then fill ends the mode
        segment(MK_COM, 16'd3, 1, '0, '0, '0);
        send(8'h5A, 1'b0);
        segment(8'hE1, 16'd4, 1, '0, '0, '0);
        // two strays after a comment: the next byte is the marker, with fix-up
        segment(MK_COM, LEN_MIN, 0, '0, '0, '0);
        send(8'h12, 1'b0);
        send(8'h34, 1'b0);
        segment(8'hEC, 16'd3, 0, '0, '0, '0);
        segment(8'hCF, 16'd12, 0, 16'h0000, 16'hFFFF, 8'h01);

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) random_segment();
        end_scan();

        // taken and dropped once the scan has ended
        repeat (8) send(8'($urandom), 1'($urandom));
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("** jpeg_marker_segment_scanner_top: PASSED **");
        end else begin
            $display("** jpeg_marker_segment_scanner_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("** jpeg_marker_segment_scanner_top: FAILED **");
        $finish;
    end

endmodule
